// ===== hdl/rpc_pkg.sv =====
// Shared types and constants for the ROM page cache lookup block.
package rpc_pkg;

  localparam int ADDR_W     = 24;
  localparam int OFFSET_W   = 14;
  localparam int PAGE_W     = 9;
  localparam int SLOT_W     = 3;
  localparam int SLOTS_W    = SLOT_W + 1;
  localparam int MAX_SLOTS  = 8;
  localparam int PAGE_BYTES = 16384;
  localparam int PAGE_COUNT = 512;
  localparam int FILL_W     = 15;
  localparam int AGE_W      = 32;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [ADDR_W-1:0]  ROM_LIMIT = ADDR_W'(PAGE_COUNT * PAGE_BYTES);
  localparam logic [SLOTS_W-1:0] SLOTS_MAX = SLOTS_W'(MAX_SLOTS);
  localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(PAGE_BYTES);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES = 2'd2;

  typedef enum logic [1:0] {
    ST_RANGE  = 2'd0,
    ST_BYPASS = 2'd1,
    ST_HIT    = 2'd2,
    ST_MISS   = 2'd3
  } status_t;

  typedef struct packed {
    logic [PAGE_W-1:0] tag;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [PAGE_W-1:0]  page;
    logic [SLOTS_W-1:0] slots;
  } lookup_req_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } lookup_rsp_t;

endpackage

// ===== hdl/rpc_lookup.sv =====
// Tag/age store with sequential scan: hit detection, LRU victim pick and retag.
module rpc_lookup (
  input  logic                clk,
  input  logic                rst_n,
  input  rpc_pkg::lookup_req_t req,
  output rpc_pkg::lookup_rsp_t rsp
);

  typedef enum logic {
    L_IDLE,
    L_SCAN
  } lstate_t;

  lstate_t state_r;

  rpc_pkg::entry_t mem [rpc_pkg::MAX_SLOTS];
  rpc_pkg::entry_t rd_data_r;

  logic [rpc_pkg::MAX_SLOTS-1:0] tag_valid_r;
  logic [rpc_pkg::AGE_W-1:0]     tick_r;
  logic [rpc_pkg::PAGE_W-1:0]    recent_page_r;
  logic                          recent_valid_r;
  logic [rpc_pkg::SLOT_W-1:0]    recent_slot_r;

  logic [rpc_pkg::PAGE_W-1:0]    page_r;
  logic [rpc_pkg::SLOTS_W-1:0]   slots_r;
  logic [rpc_pkg::SLOT_W-1:0]    cnt_r;
  logic [rpc_pkg::SLOT_W-1:0]    vic_r;
  logic [rpc_pkg::AGE_W-1:0]     vic_age_r;

  logic                          done_r;
  logic                          hit_r;
  logic [rpc_pkg::SLOT_W-1:0]    slot_r;

  logic                          ent_valid;
  logic [rpc_pkg::AGE_W-1:0]     ent_age;
  logic                          match;
  logic                          last;
  logic [rpc_pkg::SLOT_W-1:0]    cand;
  logic [rpc_pkg::SLOT_W-1:0]    rd_addr;
  logic                          wr_en;
  logic [rpc_pkg::SLOT_W-1:0]    wr_addr;
  rpc_pkg::entry_t               wr_data;

  // entry under test is the one read out for cnt_r; an empty entry has age zero
  always_comb begin
    ent_valid = tag_valid_r[cnt_r];
    ent_age   = ent_valid ? rd_data_r.age : '0;
    match     = ent_valid && (rd_data_r.tag == page_r);
    last      = ({1'b0, cnt_r} == (slots_r - rpc_pkg::SLOTS_W'(1)));
    if ((cnt_r == '0) || !ent_valid || (ent_age < vic_age_r)) begin
      cand = cnt_r;
    end else begin
      cand = vic_r;
    end
    rd_addr      = (state_r == L_SCAN) ? cnt_r + rpc_pkg::SLOT_W'(1) : '0;
    wr_en        = (state_r == L_SCAN) && (match || last);
    wr_addr      = match ? cnt_r : cand;
    wr_data.tag  = page_r;
    wr_data.age  = tick_r;
  end

  // writes land only at the end of a scan; the next read is issued no earlier
  // than the following transaction, so no forwarding path is needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= L_IDLE;
      tag_valid_r    <= '0;
      tick_r         <= '0;
      recent_page_r  <= '0;
      recent_valid_r <= 1'b0;
      recent_slot_r  <= '0;
      done_r         <= 1'b0;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (req.start) begin
            tick_r  <= tick_r + rpc_pkg::AGE_W'(1);
            page_r  <= req.page;
            slots_r <= req.slots;
            if (recent_valid_r && (req.page == recent_page_r)) begin
              // repeat of the most recent page: hit without age refresh
              done_r <= 1'b1;
              hit_r  <= 1'b1;
              slot_r <= recent_slot_r;
            end else begin
              done_r  <= 1'b0;
              cnt_r   <= '0;
              state_r <= L_SCAN;
            end
          end else begin
            done_r <= 1'b0;
          end
        end
        L_SCAN: begin
          if (match) begin
            recent_page_r  <= page_r;
            recent_slot_r  <= cnt_r;
            recent_valid_r <= 1'b1;
            done_r         <= 1'b1;
            hit_r          <= 1'b1;
            slot_r         <= cnt_r;
            state_r        <= L_IDLE;
          end else if (last) begin
            tag_valid_r[cand] <= 1'b1;
            recent_page_r     <= page_r;
            recent_slot_r     <= cand;
            recent_valid_r    <= 1'b1;
            done_r            <= 1'b1;
            hit_r             <= 1'b0;
            slot_r            <= cand;
            state_r           <= L_IDLE;
          end else begin
            done_r <= 1'b0;
            vic_r  <= cand;
            if (cand == cnt_r) begin
              vic_age_r <= ent_age;
            end
            cnt_r <= cnt_r + rpc_pkg::SLOT_W'(1);
          end
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= L_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.hit  = hit_r;
  assign rsp.slot = slot_r;

endmodule

// ===== hdl/rom_page_cache_lru_unit.sv =====
// Top level: ROM page cache lookup with LRU replacement and fill command output.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_ready  in_read_address
//   out_     out  out_valid/out_ready out_status, out_slot, out_page, out_page_offset,
//                                    out_fill_bytes, out_hit_total, out_miss_total
//   cfg_     in   cfg_wr_en          cfg_index, cfg_data
//
// One transaction at a time. Out of range and bypass go from T_IDLE straight to T_DONE;
// a repeat of the most recent page is answered without a scan; a tag scan reads one store entry
// per cycle through the single read port of the tag/age memory and stops at the first
// match, or on a miss at the last configured slot. in_ready returns together with out_valid
// when the output register loads. Reset empties the cache and clears the counters.
// A new input is taken while a result still waits on out_ready; a finished
// lookup holds until the output register frees up.
module rom_page_cache_lru_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rpc_pkg::ADDR_W-1:0]    in_read_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [rpc_pkg::SLOT_W-1:0]    out_slot,
  output logic [rpc_pkg::PAGE_W-1:0]    out_page,
  output logic [rpc_pkg::OFFSET_W-1:0]  out_page_offset,
  output logic [rpc_pkg::FILL_W-1:0]    out_fill_bytes,
  output logic [rpc_pkg::TOTAL_W-1:0]   out_hit_total,
  output logic [rpc_pkg::TOTAL_W-1:0]   out_miss_total,
  input  logic                          cfg_wr_en,
  input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_LOOK,
    T_DONE
  } tstate_t;

  tstate_t state_r;

  logic                           cache_enable_r;
  logic [rpc_pkg::SLOTS_W-1:0]    cache_pages_r;
  logic [rpc_pkg::ADDR_W-1:0]     rom_bytes_r;

  logic [rpc_pkg::PAGE_W-1:0]     page_r;
  logic [rpc_pkg::OFFSET_W-1:0]   offset_r;
  rpc_pkg::status_t               status_r;
  logic [rpc_pkg::SLOT_W-1:0]     slot_r;
  logic [rpc_pkg::FILL_W-1:0]     fill_r;
  logic [rpc_pkg::TOTAL_W-1:0]    hit_total_r;
  logic [rpc_pkg::TOTAL_W-1:0]    miss_total_r;

  logic                           out_valid_r;
  logic [1:0]                     out_status_r;
  logic [rpc_pkg::SLOT_W-1:0]     out_slot_r;
  logic [rpc_pkg::PAGE_W-1:0]     out_page_r;
  logic [rpc_pkg::OFFSET_W-1:0]   out_offset_r;
  logic [rpc_pkg::FILL_W-1:0]     out_fill_r;
  logic [rpc_pkg::TOTAL_W-1:0]    out_hit_r;
  logic [rpc_pkg::TOTAL_W-1:0]    out_miss_r;

  logic                           in_fire;
  logic [rpc_pkg::ADDR_W-1:0]     rom_eff;
  logic [rpc_pkg::SLOTS_W-1:0]    slots_eff;
  logic                           out_of_range;
  logic                           cacheable;
  logic [rpc_pkg::PAGE_W-1:0]     addr_page;
  logic [rpc_pkg::OFFSET_W-1:0]   addr_offset;
  logic [rpc_pkg::ADDR_W-1:0]     page_base;
  logic [rpc_pkg::ADDR_W-1:0]     remain;
  logic [rpc_pkg::FILL_W-1:0]     fill_calc;

  rpc_pkg::lookup_req_t           req;
  rpc_pkg::lookup_rsp_t           rsp;

  assign in_ready = (state_r == T_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    rom_eff      = (rom_bytes_r > rpc_pkg::ROM_LIMIT) ? rpc_pkg::ROM_LIMIT : rom_bytes_r;
    slots_eff    = (cache_pages_r > rpc_pkg::SLOTS_MAX) ? rpc_pkg::SLOTS_MAX : cache_pages_r;
    out_of_range = (in_read_address >= rom_eff);
    cacheable    = cache_enable_r && (slots_eff != '0);
    addr_page    = in_read_address[rpc_pkg::OFFSET_W +: rpc_pkg::PAGE_W];
    addr_offset  = in_read_address[rpc_pkg::OFFSET_W-1:0];
    // bytes left in ROM from the page start, capped at one page
    page_base    = {{(rpc_pkg::ADDR_W - rpc_pkg::PAGE_W - rpc_pkg::OFFSET_W){1'b0}},
                    page_r, {rpc_pkg::OFFSET_W{1'b0}}};
    remain       = rom_eff - page_base;
    fill_calc    = (remain >= rpc_pkg::ADDR_W'(rpc_pkg::PAGE_BYTES)) ?
                   rpc_pkg::FILL_FULL : remain[rpc_pkg::FILL_W-1:0];
    req.start    = in_fire && !out_of_range && cacheable;
    req.page     = addr_page;
    req.slots    = slots_eff;
  end

  rpc_lookup u_lookup (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= T_IDLE;
      cache_enable_r <= 1'b0;
      cache_pages_r  <= '0;
      rom_bytes_r    <= '0;
      hit_total_r    <= '0;
      miss_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rpc_pkg::CFG_ENABLE:    cache_enable_r <= cfg_data[0];
          rpc_pkg::CFG_PAGES:     cache_pages_r  <= cfg_data[rpc_pkg::SLOTS_W-1:0];
          rpc_pkg::CFG_ROM_BYTES: rom_bytes_r    <= cfg_data;
          default: ;
        endcase
      end

      // a load in T_DONE takes the place of the clear
      if (out_valid_r && out_ready && (state_r != T_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        T_IDLE: begin
          if (in_fire) begin
            page_r   <= addr_page;
            offset_r <= addr_offset;
            slot_r   <= '0;
            fill_r   <= '0;
            if (out_of_range) begin
              status_r <= rpc_pkg::ST_RANGE;
              state_r  <= T_DONE;
            end else if (!cacheable) begin
              status_r <= rpc_pkg::ST_BYPASS;
              state_r  <= T_DONE;
            end else begin
              state_r <= T_LOOK;
            end
          end
        end
        T_LOOK: begin
          if (rsp.done) begin
            slot_r <= rsp.slot;
            if (rsp.hit) begin
              status_r    <= rpc_pkg::ST_HIT;
              hit_total_r <= hit_total_r + rpc_pkg::TOTAL_W'(1);
            end else begin
              status_r     <= rpc_pkg::ST_MISS;
              miss_total_r <= miss_total_r + rpc_pkg::TOTAL_W'(1);
              fill_r       <= fill_calc;
            end
            state_r <= T_DONE;
          end
        end
        T_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_slot_r   <= slot_r;
            out_page_r   <= page_r;
            out_offset_r <= offset_r;
            out_fill_r   <= fill_r;
            out_hit_r    <= hit_total_r;
            out_miss_r   <= miss_total_r;
            state_r      <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_page        = out_page_r;
  assign out_page_offset = out_offset_r;
  assign out_fill_bytes  = out_fill_r;
  assign out_hit_total   = out_hit_r;
  assign out_miss_total  = out_miss_r;

endmodule
